[sv/b7tsag_pkg.sv]
package b7tsag_pkg;

	localparam int DIGIT_W = 3;
	localparam int ADDR_W  = 18;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	localparam digit_t DIGIT_MAX = 3'd6;

	// configuration register indexes
	localparam logic REG_LOCK_DEPTH = 1'b0;
	localparam logic REG_CLOCK_SEL  = 1'b1;

	// input kinds
	localparam logic KIND_ADVANCE = 1'b0;
	localparam logic KIND_WRITE   = 1'b1;

	typedef struct packed {
		logic clear;
		logic en;
	} mac_ctrl_t;

endpackage

[sv/base7_tree_step_address_generator.sv]
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: digit_position, digit_value; tuser: kind
// m_axis    out  m_axis_tvalid/tready       tdata: level .. clock_gate; tlast: last
// cfg       in   cfg_we (no back-pressure)  cfg_index, cfg_data
//
// A write item gives no result.
// An advance item updates all digits in the cycle it is accepted, then emits
// LEVELS+1 results through one shared multiply-accumulate, one a cycle while
// the output is not stalled.
// Input is not ready while the results of an advance are being emitted.
// Output stalls hold the result register and the sequencer.
// Reset clears the digits and loads lock_depth = 3, clock_depth_select = 0.
module base7_tree_step_address_generator #(
	parameter int LEVELS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [2:0] digit_position, [5:3] digit_value
	input  logic        s_axis_tuser,  // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] level, [20:3] step_address, [23:21] position, [26:24] sub_position,
	// [27] has_previous, [33:28] rollover_mask, [34] clock_gate
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data
);

	localparam int LvlW = $clog2(LEVELS + 1);

	typedef enum logic {ST_IDLE, ST_EMIT} state_t;

	typedef logic [LEVELS:0][b7tsag_pkg::ADDR_W-1:0] weight_tab_t;

	// weight of digit i: 1 + 7 + ... + 7^(LEVELS-i-1); zero past the deepest level
	function automatic weight_tab_t weight_table();
		weight_tab_t  t;
		logic [31:0]  w;
		logic [31:0]  p;
		t = '0;
		for (int i = 0; i < LEVELS; i++) begin
			w = '0;
			p = 32'd1;
			for (int k = i; k < LEVELS; k++) begin
				w = w + p;
				p = p * 32'd7;
			end
			t[i] = b7tsag_pkg::addr_t'(w);
		end
		return t;
	endfunction

	localparam weight_tab_t WEIGHT = weight_table();

	state_t              state_q;
	logic [LvlW-1:0]     lvl_q;
	logic [2:0]          lock_q;
	logic [2:0]          clk_sel_q;
	b7tsag_pkg::digit_t  digit_q [LEVELS];
	b7tsag_pkg::digit_t  snap_q [LEVELS+1];
	logic [5:0]          roll_q;
	logic                gate_q;

	logic                out_valid_q;
	logic [2:0]          out_level_q;
	b7tsag_pkg::addr_t   out_addr_q;
	b7tsag_pkg::digit_t  out_pos_q;
	b7tsag_pkg::digit_t  out_sub_q;
	logic                out_prev_q;
	logic [5:0]          out_roll_q;
	logic                out_gate_q;
	logic                out_last_q;

	b7tsag_pkg::digit_t  next_digit [LEVELS];
	logic [LEVELS-1:0]   rolls;
	logic [2:0]          clk_digit;
	logic                gate_next;
	logic                in_acc;
	logic                adv_acc;
	logic                wr_acc;
	logic                load_out;
	logic                lvl_in;
	logic                lvl_sub_in;
	logic                lvl_end;
	b7tsag_pkg::mac_ctrl_t mac_ctrl;
	b7tsag_pkg::addr_t   acc;
	b7tsag_pkg::digit_t  wr_pos;
	b7tsag_pkg::digit_t  wr_val;

	assign wr_pos  = s_axis_tdata[2:0];
	assign wr_val  = s_axis_tdata[5:3];
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign adv_acc = in_acc && (s_axis_tuser == b7tsag_pkg::KIND_ADVANCE);
	assign wr_acc  = in_acc && (s_axis_tuser == b7tsag_pkg::KIND_WRITE);
	assign s_axis_tready = (state_q == ST_IDLE);

	// carry from the deepest digit upward, never below the lock depth
	always_comb begin
		logic prop;
		prop = 1'b1;
		rolls = '0;
		for (int d = LEVELS - 1; d >= 0; d--) begin
			next_digit[d] = digit_q[d];
			if (prop && ({1'b0, lock_q} <= 4'(d))) begin
				if (digit_q[d] == b7tsag_pkg::DIGIT_MAX) begin
					next_digit[d] = '0;
					rolls[d] = 1'b1;
				end else begin
					next_digit[d] = digit_q[d] + b7tsag_pkg::digit_t'(1);
					prop = 1'b0;
				end
			end else begin
				prop = 1'b0;
			end
		end
	end

	assign clk_digit = (clk_sel_q == 3'd0) ? lock_q : clk_sel_q - 3'd1;

	always_comb begin
		gate_next = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (({1'b0, clk_digit} == 4'(i)) && (next_digit[i] == '0))
				gate_next = 1'b1;
		end
	end

	assign load_out   = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
	assign lvl_in     = (lvl_q < LvlW'(LEVELS));
	assign lvl_sub_in = ((LvlW+1)'(lvl_q) + (LvlW+1)'(1)) < (LvlW+1)'(LEVELS);
	assign lvl_end    = (lvl_q == LvlW'(LEVELS));

	assign mac_ctrl.clear = adv_acc;
	assign mac_ctrl.en    = load_out && lvl_in;

	b7tsag_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.digit  (snap_q[0]),
		.weight (WEIGHT[lvl_q]),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lvl_q       <= '0;
			lock_q      <= 3'd3;
			clk_sel_q   <= 3'd0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++)
				digit_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					b7tsag_pkg::REG_LOCK_DEPTH: lock_q    <= cfg_data;
					b7tsag_pkg::REG_CLOCK_SEL:  clk_sel_q <= cfg_data;
					default: ;
				endcase
			end

			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (wr_acc && ({1'b0, wr_pos} < 4'(LEVELS))
							&& (wr_val <= b7tsag_pkg::DIGIT_MAX)) begin
						for (int i = 0; i < LEVELS; i++)
							if (wr_pos == 3'(i))
								digit_q[i] <= wr_val;
					end
					if (adv_acc) begin
						for (int i = 0; i < LEVELS; i++) begin
							digit_q[i] <= next_digit[i];
							snap_q[i]  <= next_digit[i];
						end
						snap_q[LEVELS] <= '0;
						roll_q  <= 6'(rolls);
						gate_q  <= gate_next;
						lvl_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						out_level_q <= 3'(lvl_q);
						out_addr_q  <= acc;
						out_pos_q   <= lvl_in ? snap_q[0] + b7tsag_pkg::digit_t'(1)
							: b7tsag_pkg::digit_t'(1);
						out_sub_q   <= lvl_sub_in ? snap_q[1] + b7tsag_pkg::digit_t'(1)
							: b7tsag_pkg::digit_t'(7);
						out_prev_q  <= lvl_in;
						out_roll_q  <= roll_q;
						out_gate_q  <= gate_q;
						out_last_q  <= lvl_end;
						// advance the snapshot so the current level sits at the bottom
						for (int i = 0; i < LEVELS; i++)
							snap_q[i] <= snap_q[i+1];
						snap_q[LEVELS] <= '0;
						lvl_q <= lvl_q + LvlW'(1);
						if (lvl_end)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {5'd0, out_gate_q, out_roll_q, out_prev_q, out_sub_q,
		out_pos_q, out_addr_q, out_level_q};

`ifndef SYNTHESIS
	a_adv_starts_emit: assert property (@(posedge clk) disable iff (!arst_n)
		adv_acc |=> (state_q == ST_EMIT) && (lvl_q == '0))
		else $error("advance did not start emission at the root");

	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (lvl_q <= LvlW'(LEVELS)))
		else $error("level counter ran past the deepest level");

	a_prev_vs_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_prev_q != out_last_q))
		else $error("has_previous and last disagree");

	a_last_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_level_q == 3'(LEVELS)))
		else $error("last result not at the deepest level");

	a_root_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (lvl_q == '0)) |=> (out_addr_q == '0))
		else $error("root result with non-zero address");
`endif

endmodule

[sv/b7tsag_mac.sv]
// Shared multiply-accumulate for the flat step address: acc += digit * weight + 1.
module b7tsag_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b7tsag_pkg::mac_ctrl_t ctrl,
	input  b7tsag_pkg::digit_t    digit,
	input  b7tsag_pkg::addr_t     weight,
	output b7tsag_pkg::addr_t     acc
);

	b7tsag_pkg::addr_t acc_q;
	b7tsag_pkg::addr_t term;

	// modulo 2^18, matching the field width
	assign term = b7tsag_pkg::addr_t'(b7tsag_pkg::addr_t'(digit) * weight)
		+ b7tsag_pkg::addr_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.en) begin
			acc_q <= acc_q + term;
		end
	end

	assign acc = acc_q;

endmodule
